FILE: rtl/fpp_pkg.sv
// Shared types and constants for the framed packet parser.
// No dependencies; design files use scoped names into it; the benches import it.
package fpp_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [7:0] LEN_LIMIT = 8'(MAX_PAYLOAD);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] START_BYTE_INIT = 8'd170;
	localparam logic [15:0] TIMEOUT_INIT = 16'd100;

	localparam logic REG_START_BYTE = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [2:0] {
		ST_NONE = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_OVERSIZE = 3'd2,
		ST_CSUM_ERR = 3'd3,
		ST_READY = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_LENGTH,
		PH_COMMAND,
		PH_PAYLOAD,
		PH_CHECKSUM
	} phase_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_READ,
		BK_SEND
	} back_state_t;

	typedef struct packed {
		status_t status;
		logic [7:0] cmd;
		logic [5:0] len;
	} request_t;

	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [7:0] data;
	} store_wr_t;

	typedef struct packed {
		logic full;
		logic busy;
	} hold_t;

endpackage

FILE: rtl/fpp_if.sv
// Channel interfaces of the framed packet parser: byte input and result output.
// Depends on nothing.
interface fpp_in_if;
	logic valid;
	logic ready;
	logic func;
	logic [7:0] data_byte;
	logic [31:0] now_ms;

	modport source (output valid, func, data_byte, now_ms, input ready);
	modport sink (input valid, func, data_byte, now_ms, output ready);
endinterface

interface fpp_out_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [7:0] frame_command;
	logic [5:0] frame_length;
	logic [7:0] payload_byte;
	logic payload_valid;
	logic last;

	modport source (output valid, status, frame_command, frame_length, payload_byte,
		payload_valid, last, input ready);
	modport sink (input valid, status, frame_command, frame_length, payload_byte,
		payload_valid, last, output ready);
endinterface

FILE: rtl/fpp_front.sv
// Front end: accepts bytes and polls, runs the framing state machine, fills the payload store
// and queues one request per input. Depends on fpp_pkg and fpp_if.
module fpp_front (
	input logic clk,
	input logic arst_n,
	fpp_in_if.sink rx,
	input logic [7:0] start_byte,
	input logic [15:0] timeout_limit_ms,
	input fpp_pkg::hold_t hold,
	output logic push,
	output fpp_pkg::request_t push_req,
	output fpp_pkg::store_wr_t store_wr
);

	fpp_pkg::phase_t phase_q, phase_d, ph_eff;
	logic [5:0] len_q, len_d, len_eff;
	logic [7:0] cmd_q, cmd_d, cmd_eff;
	logic [5:0] fill_q, fill_d, fill_eff, fill_inc;
	logic [7:0] sum_q, sum_d, sum_eff, sum_add;
	logic [31:0] lbt_q, lbt_d;
	logic [31:0] gap;
	logic timeout;
	logic accept;
	logic is_start;

	assign rx.ready = !hold.full && !(phase_q == fpp_pkg::PH_PAYLOAD && hold.busy);
	assign accept = rx.valid && rx.ready;
	assign push = accept;

	assign gap = rx.now_ms - lbt_q;
	assign timeout = (phase_q != fpp_pkg::PH_WAIT) && (gap > {16'd0, timeout_limit_ms});
	assign ph_eff = timeout ? fpp_pkg::PH_WAIT : phase_q;
	assign len_eff = timeout ? 6'd0 : len_q;
	assign cmd_eff = timeout ? 8'd0 : cmd_q;
	assign fill_eff = timeout ? 6'd0 : fill_q;
	assign sum_eff = timeout ? 8'd0 : sum_q;
	assign fill_inc = fill_eff + 6'd1;
	assign sum_add = sum_eff + rx.data_byte;
	assign is_start = (rx.data_byte == start_byte);

	always_comb begin
		phase_d = ph_eff;
		if (!rx.func) begin
			case (ph_eff)
				fpp_pkg::PH_WAIT: begin
					if (is_start) phase_d = fpp_pkg::PH_LENGTH;
				end
				fpp_pkg::PH_LENGTH: begin
					if (rx.data_byte > fpp_pkg::LEN_LIMIT)
						phase_d = is_start ? fpp_pkg::PH_LENGTH : fpp_pkg::PH_WAIT;
					else
						phase_d = fpp_pkg::PH_COMMAND;
				end
				fpp_pkg::PH_COMMAND: begin
					phase_d = (len_eff == 6'd0) ? fpp_pkg::PH_CHECKSUM : fpp_pkg::PH_PAYLOAD;
				end
				fpp_pkg::PH_PAYLOAD: begin
					if (fill_inc >= len_eff) phase_d = fpp_pkg::PH_CHECKSUM;
				end
				fpp_pkg::PH_CHECKSUM: begin
					phase_d = (sum_add != 8'd0 && is_start) ? fpp_pkg::PH_LENGTH
						: fpp_pkg::PH_WAIT;
				end
				default: phase_d = fpp_pkg::PH_WAIT;
			endcase
		end
	end

	always_comb begin
		len_d = len_eff;
		cmd_d = cmd_eff;
		fill_d = fill_eff;
		sum_d = sum_eff;
		lbt_d = rx.func ? lbt_q : rx.now_ms;
		push_req.status = timeout ? fpp_pkg::ST_TIMEOUT : fpp_pkg::ST_NONE;
		push_req.cmd = 8'd0;
		push_req.len = 6'd0;
		store_wr.en = 1'b0;
		store_wr.addr = fill_eff[fpp_pkg::ADDR_W-1:0];
		store_wr.data = rx.data_byte;
		if (!rx.func) begin
			case (ph_eff)
				fpp_pkg::PH_WAIT: begin
				end
				fpp_pkg::PH_LENGTH: begin
					if (rx.data_byte > fpp_pkg::LEN_LIMIT) begin
						push_req.status = fpp_pkg::ST_OVERSIZE;
					end else begin
						len_d = rx.data_byte[5:0];
						sum_d = rx.data_byte;
					end
				end
				fpp_pkg::PH_COMMAND: begin
					cmd_d = rx.data_byte;
					sum_d = sum_add;
				end
				fpp_pkg::PH_PAYLOAD: begin
					store_wr.en = accept;
					fill_d = fill_inc;
					sum_d = sum_add;
				end
				fpp_pkg::PH_CHECKSUM: begin
					len_d = 6'd0;
					cmd_d = 8'd0;
					fill_d = 6'd0;
					sum_d = 8'd0;
					if (sum_add != 8'd0) begin
						push_req.status = fpp_pkg::ST_CSUM_ERR;
					end else begin
						push_req.status = fpp_pkg::ST_READY;
						push_req.cmd = cmd_eff;
						push_req.len = len_eff;
					end
				end
				default: begin
					len_d = 6'd0;
					cmd_d = 8'd0;
					fill_d = 6'd0;
					sum_d = 8'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fpp_pkg::PH_WAIT;
			len_q <= 6'd0;
			cmd_q <= 8'd0;
			fill_q <= 6'd0;
			sum_q <= 8'd0;
			lbt_q <= 32'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			len_q <= len_d;
			cmd_q <= cmd_d;
			fill_q <= fill_d;
			sum_q <= sum_d;
			lbt_q <= lbt_d;
		end
	end

endmodule

FILE: rtl/fpp_queue.sv
// Short request queue between the front and back ends of the parser.
// Depends on fpp_pkg.
module fpp_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input fpp_pkg::request_t push_req,
	input logic pop,
	output fpp_pkg::request_t head,
	output logic full,
	output logic empty
);

	fpp_pkg::request_t entry_q [fpp_pkg::QUEUE_DEPTH];
	logic [fpp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [fpp_pkg::QPTR_W:0] count_q;

	assign full = (count_q == (fpp_pkg::QPTR_W+1)'(fpp_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/fpp_back.sv
// Back end: pops requests, holds the payload store and drives the result register,
// one result per byte of a nonempty good frame. Depends on fpp_pkg and fpp_if.
module fpp_back (
	input logic clk,
	input logic arst_n,
	input fpp_pkg::store_wr_t store_wr,
	input fpp_pkg::request_t head,
	input logic empty,
	output logic pop,
	output logic active,
	fpp_out_if.source res
);

	logic [7:0] store_mem [fpp_pkg::MAX_PAYLOAD];
	logic [7:0] rd_data_q;
	fpp_pkg::back_state_t state_q, state_d;
	logic [7:0] cmd_q;
	logic [5:0] len_q;
	logic [5:0] idx_q;
	logic slot_free;
	logic rd_en;
	logic load_single;
	logic load_byte;
	logic is_frame;
	logic idx_last;

	logic out_valid_q;
	fpp_pkg::status_t status_q;
	logic [7:0] command_q;
	logic [5:0] length_q;
	logic [7:0] pbyte_q;
	logic pvalid_q;
	logic last_q;

	assign slot_free = !out_valid_q || res.ready;
	assign is_frame = (head.status == fpp_pkg::ST_READY) && (head.len != 6'd0);
	assign idx_last = ((idx_q + 6'd1) == len_q);
	assign active = (state_q != fpp_pkg::BK_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			fpp_pkg::BK_IDLE: begin
				if (!empty && slot_free && is_frame) state_d = fpp_pkg::BK_READ;
			end
			fpp_pkg::BK_READ: state_d = fpp_pkg::BK_SEND;
			fpp_pkg::BK_SEND: begin
				if (slot_free) state_d = idx_last ? fpp_pkg::BK_IDLE : fpp_pkg::BK_READ;
			end
			default: state_d = fpp_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		load_single = 1'b0;
		load_byte = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			fpp_pkg::BK_IDLE: begin
				pop = !empty && slot_free;
				load_single = pop && !is_frame;
			end
			fpp_pkg::BK_READ: rd_en = 1'b1;
			fpp_pkg::BK_SEND: load_byte = slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
		if (rd_en) rd_data_q <= store_mem[idx_q[fpp_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpp_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			idx_q <= 6'd0;
		end else begin
			state_q <= state_d;
			if (pop) idx_q <= 6'd0;
			else if (load_byte) idx_q <= idx_q + 6'd1;
			if (load_single || load_byte) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head.cmd;
			len_q <= head.len;
		end
		if (load_single) begin
			status_q <= head.status;
			command_q <= head.cmd;
			length_q <= head.len;
			pbyte_q <= 8'd0;
			pvalid_q <= 1'b0;
			last_q <= 1'b1;
		end else if (load_byte) begin
			status_q <= fpp_pkg::ST_READY;
			command_q <= cmd_q;
			length_q <= len_q;
			pbyte_q <= rd_data_q;
			pvalid_q <= 1'b1;
			last_q <= idx_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.status = status_q;
	assign res.frame_command = command_q;
	assign res.frame_length = length_q;
	assign res.payload_byte = pbyte_q;
	assign res.payload_valid = pvalid_q;
	assign res.last = last_q;

endmodule

FILE: rtl/framed_packet_parser.sv
// Top level of the framed packet parser: configuration registers and the front, queue
// and back ends. Depends on fpp_pkg, fpp_if, fpp_front, fpp_queue and fpp_back.
//
//   channel   dir   handshake              carries
//   rx        in    valid/ready            func, data_byte, now_ms
//   res       out   valid/ready            status, frame_command, frame_length,
//                                          payload_byte, payload_valid, last
//   apb       in    psel/penable/pready    start_byte at 0x0, timeout_limit_ms at 0x4
//
// Each accepted input queues one request; up to four requests wait.
// A single-result request is loaded straight into the result register; a good frame
// with payload takes a read and a send state per byte, for the registered store read.
// While the front end is in the payload phase it holds off input until the queue
// and back end drain. Both sides stall independently; reset clears all control state.
module framed_packet_parser (
	input logic clk,
	input logic arst_n,
	fpp_in_if.sink rx,
	fpp_out_if.source res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [7:0] start_byte_q;
	logic [15:0] timeout_q;
	logic cfg_wr;
	logic push;
	logic pop;
	logic full;
	logic empty;
	logic back_active;
	fpp_pkg::request_t push_req;
	fpp_pkg::request_t head;
	fpp_pkg::store_wr_t store_wr;
	fpp_pkg::hold_t hold;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == fpp_pkg::REG_TIMEOUT) ? {16'd0, timeout_q}
		: {24'd0, start_byte_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= fpp_pkg::START_BYTE_INIT;
			timeout_q <= fpp_pkg::TIMEOUT_INIT;
		end else if (cfg_wr) begin
			if (paddr[2] == fpp_pkg::REG_START_BYTE) start_byte_q <= pwdata[7:0];
			else timeout_q <= pwdata[15:0];
		end
	end

	assign hold.full = full;
	assign hold.busy = !empty || back_active;

	fpp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx),
		.start_byte(start_byte_q),
		.timeout_limit_ms(timeout_q),
		.hold(hold),
		.push(push),
		.push_req(push_req),
		.store_wr(store_wr)
	);

	fpp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_req(push_req),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	fpp_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.store_wr(store_wr),
		.head(head),
		.empty(empty),
		.pop(pop),
		.active(back_active),
		.res(res)
	);

endmodule

FILE: verif/framed_packet_parser_checker.sv
`timescale 1ns / 100ps
// Result checker for the framed packet parser: watches the request, result and register
// ports, predicts each result from its own parser state and compares it field by field.
// Depends on fpp_pkg and fpp_if.
module framed_packet_parser_checker (
	input logic clk,
	input logic arst_n,
	fpp_in_if rx,
	fpp_out_if res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output int mismatches,
	output int outstanding,
	output int compared
);
	import fpp_pkg::*;

	typedef struct packed {
		status_t status;
		logic [7:0] cmd;
		logic [5:0] len;
		logic [7:0] pbyte;
		logic pvalid;
		logic last;
	} report_t;

	report_t due_reports[$];

	logic [7:0] sof;
	logic [15:0] limit_ms;
	phase_t ph;
	logic [5:0] want_len;
	logic [7:0] cmd_hold;
	logic [5:0] fill;
	logic [7:0] csum;
	logic [31:0] stamp;
	logic [7:0] payload_mem [MAX_PAYLOAD];

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic void post(input status_t st, input logic [7:0] c, input logic [5:0] n,
		input logic [7:0] pb, input logic pv, input logic lst);
		report_t r;
		r.status = st;
		r.cmd = c;
		r.len = n;
		r.pbyte = pb;
		r.pvalid = pv;
		r.last = lst;
		due_reports.push_back(r);
	endfunction

	function automatic void abandon_frame();
		ph = PH_WAIT;
		want_len = '0;
		cmd_hold = '0;
		fill = '0;
		csum = '0;
	endfunction

	function automatic void deframe(input logic fn, input logic [7:0] b, input logic [31:0] now);
		status_t st;
		logic [31:0] gap;
		st = ST_NONE;
		gap = now - stamp;
		if (ph != PH_WAIT && gap > {16'd0, limit_ms}) begin
			abandon_frame();
			st = ST_TIMEOUT;
		end
		if (fn) begin
			post(st, 8'd0, 6'd0, 8'd0, 1'b0, 1'b1);
			return;
		end
		stamp = now;
		case (ph)
		PH_WAIT: begin
			if (b == sof)
				ph = PH_LENGTH;
		end
		PH_LENGTH: begin
			if (b > LEN_LIMIT) begin
				abandon_frame();
				if (b == sof)
					ph = PH_LENGTH;
				st = ST_OVERSIZE;
			end else begin
				want_len = b[5:0];
				csum = b;
				ph = PH_COMMAND;
			end
		end
		PH_COMMAND: begin
			cmd_hold = b;
			csum = 8'(csum + b);
			ph = (want_len == 6'd0) ? PH_CHECKSUM : PH_PAYLOAD;
		end
		PH_PAYLOAD: begin
			payload_mem[fill[4:0]] = b;
			fill = fill + 6'd1;
			csum = 8'(csum + b);
			if (fill >= want_len)
				ph = PH_CHECKSUM;
		end
		PH_CHECKSUM: begin
			if (8'(csum + b) != 8'd0) begin
				abandon_frame();
				if (b == sof)
					ph = PH_LENGTH;
				st = ST_CSUM_ERR;
			end else if (want_len == 6'd0) begin
				post(ST_READY, cmd_hold, 6'd0, 8'd0, 1'b0, 1'b1);
				abandon_frame();
				return;
			end else begin
				for (int k = 0; k < want_len; k++)
					post(ST_READY, cmd_hold, want_len, payload_mem[k], 1'b1,
						(k + 1 == want_len));
				abandon_frame();
				return;
			end
		end
		default: abandon_frame();
		endcase
		post(st, 8'd0, 6'd0, 8'd0, 1'b0, 1'b1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		report_t want;
		if (!arst_n) begin
			sof = START_BYTE_INIT;
			limit_ms = TIMEOUT_INIT;
			abandon_frame();
			stamp = '0;
			due_reports.delete();
			mismatches = 0;
			compared = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[2])
				REG_START_BYTE: sof = pwdata[7:0];
				REG_TIMEOUT: limit_ms = pwdata[15:0];
				endcase
			end
			if (res.valid && res.ready) begin
				if (due_reports.size() == 0) begin
					flag($sformatf("result with nothing due, status %0d", res.status));
				end else begin
					want = due_reports.pop_front();
					compared++;
					if (res.status !== want.status)
						flag($sformatf("status %0d, want %0d", res.status, want.status));
					if (res.frame_command !== want.cmd)
						flag($sformatf("frame_command %h, want %h", res.frame_command, want.cmd));
					if (res.frame_length !== want.len)
						flag($sformatf("frame_length %0d, want %0d", res.frame_length, want.len));
					if (res.payload_byte !== want.pbyte)
						flag($sformatf("payload_byte %h, want %h", res.payload_byte, want.pbyte));
					if (res.payload_valid !== want.pvalid)
						flag($sformatf("payload_valid %b, want %b", res.payload_valid,
							want.pvalid));
					if (res.last !== want.last)
						flag($sformatf("last %b, want %b", res.last, want.last));
				end
			end
			if (rx.valid && rx.ready)
				deframe(rx.func, rx.data_byte, rx.now_ms);
		end
		outstanding = due_reports.size();
	end

endmodule

FILE: verif/framed_packet_parser_tb.sv
`timescale 1ns / 100ps
// Testbench top of the framed packet parser: clock, reset, request and register stimulus,
// result stalls, watchdog and verdict. Depends on fpp_pkg, fpp_if, the parser and
// framed_packet_parser_checker.
module framed_packet_parser_tb;
	import fpp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int ITEM_TARGET = 280;
	localparam int PHASES = 6;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int mismatches;
	int outstanding;
	int compared;
	int quiet = 0;

	logic [31:0] clock_ms;
	logic [7:0] sof;
	logic [15:0] limit_ms;
	int items;
	int accepted;
	int frames;
	int settings;
	bit in_tight;
	bit out_tight;

	fpp_in_if rx_ch ();
	fpp_out_if res_ch ();

	framed_packet_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	framed_packet_parser_checker watch (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.compared(compared)
	);

	always #2 clk = ~clk;

	function automatic int draw_pause(inout bit tight);
		if ($urandom_range(0, 29) == 0)
			tight = ~tight;
		return tight ? 0 : $urandom_range(0, 18);
	endfunction

	function automatic logic [31:0] near_ms();
		if ($urandom_range(0, 7) == 0)
			return {16'd0, limit_ms};
		return $urandom_range(0, limit_ms);
	endfunction

	function automatic logic [31:0] late_ms();
		if ($urandom_range(0, 1) == 0)
			return {16'd0, limit_ms} + 32'd1;
		return $urandom_range(32'hFFFF_FFFF, {16'd0, limit_ms} + 32'd1);
	endfunction

	function automatic logic [5:0] draw_len();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 6'(MAX_PAYLOAD);
		if (r == 1)
			return 6'($urandom_range(7, MAX_PAYLOAD - 1));
		return 6'($urandom_range(0, 6));
	endfunction

	task automatic send_request(input logic fn, input logic [7:0] b, input logic [31:0] delta);
		int gap;
		gap = draw_pause(in_tight);
		clock_ms = clock_ms + delta;
		if (gap > 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_ch.valid <= 1'b1;
		rx_ch.func <= fn;
		rx_ch.data_byte <= b;
		rx_ch.now_ms <= clock_ms;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		@(negedge clk);
		accepted++;
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic settle();
		rx_ch.valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic configure(input logic [7:0] s, input logic [15:0] t);
		settle();
		write_reg(REG_START_BYTE, {24'd0, s});
		write_reg(REG_TIMEOUT, {16'd0, t});
		sof = s;
		limit_ms = t;
		settings++;
	endtask

	task automatic send_frame(input logic [5:0] len, input bit good);
		logic [7:0] sum;
		logic [7:0] cmd;
		logic [7:0] p;
		logic [7:0] ck;
		cmd = 8'($urandom);
		send_request(1'b0, sof, near_ms());
		send_request(1'b0, {2'b00, len}, near_ms());
		send_request(1'b0, cmd, near_ms());
		sum = {2'b00, len} + cmd;
		for (int k = 0; k < len; k++) begin
			p = 8'($urandom);
			sum = sum + p;
			if ($urandom_range(0, 9) == 0) begin
				send_request(1'b1, 8'($urandom), 32'd0);
				items++;
			end
			send_request(1'b0, p, near_ms());
		end
		ck = -sum;
		if (!good) begin
			if ($urandom_range(0, 3) == 0 && sof != ck)
				ck = sof;
			else
				ck = ck ^ 8'($urandom_range(1, 255));
		end
		send_request(1'b0, ck, near_ms());
		items += 4 + len;
		if (good)
			frames++;
	endtask

	task automatic send_cut_frame();
		int n;
		n = $urandom_range(0, 3);
		send_request(1'b0, sof, near_ms());
		for (int k = 0; k < n; k++)
			send_request(1'b0, 8'($urandom_range(0, 6)), near_ms());
		case ($urandom_range(0, 2))
		0: send_request(1'b1, 8'($urandom), late_ms());
		1: send_request(1'b0, sof, late_ms());
		default: send_request(1'b0, 8'($urandom), late_ms());
		endcase
		items += n + 2;
	endtask

	task automatic send_oversize();
		logic [7:0] b;
		b = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
		if (sof > LEN_LIMIT && $urandom_range(0, 2) == 0)
			b = sof;
		send_request(1'b0, sof, near_ms());
		send_request(1'b0, b, near_ms());
		items += 2;
	endtask

	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == sof)
			b = ~b;
		send_request(1'($urandom_range(0, 1)), b, near_ms());
		items++;
	endtask

	initial begin
		int stall;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_pause(out_tight);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("framed_packet_parser_tb failed");
			$finish;
		end
	end

	initial begin
		int kind;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		rx_ch.valid = 1'b0;
		rx_ch.func = 1'b0;
		rx_ch.data_byte = '0;
		rx_ch.now_ms = '0;
		sof = START_BYTE_INIT;
		limit_ms = TIMEOUT_INIT;
		clock_ms = 32'hFFFF_FFFF;
		items = 0;
		accepted = 0;
		frames = 0;
		settings = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// poll and stray byte while idle, across the time wrap
		send_request(1'b1, 8'h5A, 32'd0);
		send_request(1'b0, 8'h00, 32'd1);
		// empty frame, one gap exactly at the limit
		send_request(1'b0, sof, 32'd1);
		send_request(1'b0, 8'h00, 32'd100);
		send_request(1'b0, 8'hFF, 32'd0);
		send_request(1'b0, 8'h01, 32'd1);
		// oversize length
		send_request(1'b0, sof, 32'd2);
		send_request(1'b0, 8'd33, 32'd5);
		// oversize length equal to the start byte reopens; one-byte frame follows
		send_request(1'b0, sof, 32'd7);
		send_request(1'b0, sof, 32'd9);
		send_request(1'b0, 8'h01, 32'd1);
		send_request(1'b0, 8'h00, 32'd1);
		send_request(1'b0, 8'hFF, 32'd1);
		send_request(1'b0, 8'h00, 32'd1);
		// bad checksum equal to the start byte reopens, then a poll times out
		send_request(1'b0, sof, 32'd1);
		send_request(1'b0, 8'h00, 32'd1);
		send_request(1'b0, 8'h00, 32'd1);
		send_request(1'b0, sof, 32'd1);
		send_request(1'b1, 8'hA5, 32'd101);
		// late start byte times out and reopens; poll at the limit stays quiet
		send_request(1'b0, sof, 32'd3);
		send_request(1'b0, sof, 32'd101);
		send_request(1'b1, 8'h00, 32'd100);
		send_request(1'b0, 8'h00, 32'd0);
		send_request(1'b0, 8'h80, 32'd0);
		send_request(1'b0, 8'h80, 32'd0);
		items = accepted;

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: configure(8'h00, 16'd0);
			1: configure(8'hFF, 16'hFFFF);
			3: configure(START_BYTE_INIT, 16'($urandom_range(1, 20)));
			4: configure(8'($urandom_range(0, MAX_PAYLOAD)), 16'($urandom_range(0, 300)));
			default: configure(8'($urandom), 16'($urandom));
			endcase
			clock_ms = $urandom;
			while (items < (ph + 1) * ITEM_TARGET / PHASES) begin
				kind = $urandom_range(0, 19);
				if (kind <= 12)
					send_frame(draw_len(), 1'b1);
				else if (kind <= 14)
					send_frame(draw_len(), 1'b0);
				else if (kind == 15)
					send_oversize();
				else if (kind <= 17)
					send_cut_frame();
				else
					send_noise();
			end
		end

		settle();
		repeat (40) @(negedge clk);
		$display("covered %0d requests with %0d well-formed frames under %0d register settings",
			accepted, frames, settings + 1);
		$display("compared %0d results, %0d mismatches", compared, mismatches);
		if (mismatches == 0)
			$display("framed_packet_parser_tb passed");
		else
			$display("framed_packet_parser_tb failed");
		$finish;
	end

endmodule
